// File: sv/hrbp_pkg.sv
// ----------------------------------------------------------------------------
// hrbp_pkg: shared definitions of the HTTP request byte parser
// Result codes, byte class codes, method names and the result record that
// passes from the parser to the output buffer.
// ----------------------------------------------------------------------------
package hrbp_pkg;

  localparam int LENGTH_BITS_DEFAULT = 21;
  localparam int BODY_LEN_W          = 21;
  localparam int CFG_W               = 21;
  localparam logic [CFG_W-1:0] MAX_BODY_RESET = 21'd1048576;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_REQ_LINE  = 3'd1;
  localparam logic [2:0] EV_HDR_LINE  = 3'd2;
  localparam logic [2:0] EV_HDRS_DONE = 3'd3;
  localparam logic [2:0] EV_BODY_BYTE = 3'd4;
  localparam logic [2:0] EV_COMPLETE  = 3'd5;
  localparam logic [2:0] EV_ERROR     = 3'd6;

  localparam logic [2:0] CLS_METHOD  = 3'd0;
  localparam logic [2:0] CLS_PATH    = 3'd1;
  localparam logic [2:0] CLS_VERSION = 3'd2;
  localparam logic [2:0] CLS_NAME    = 3'd3;
  localparam logic [2:0] CLS_VALUE   = 3'd4;
  localparam logic [2:0] CLS_BODY    = 3'd5;
  localparam logic [2:0] CLS_DELIM   = 3'd6;
  localparam logic [2:0] CLS_IGNORED = 3'd7;

  localparam logic [3:0] METHOD_UNKNOWN = 4'd9;
  localparam int         NUM_METHODS    = 9;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] CL_NAME_LEN = 4'd14;

  localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd7, 4'd5, 4'd5
  };

  localparam logic [7:0] METHOD_NAME [NUM_METHODS][7] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S"},
    '{"C", "O", "N", "N", "E", "C", "T"},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00}
  };

  localparam logic [7:0] CL_NAME [14] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h"
  };

  typedef struct packed {
    logic [2:0]            event_res;
    logic [2:0]            byte_class;
    logic [7:0]            echo_byte;
    logic [3:0]            method_code;
    logic [BODY_LEN_W-1:0] body_length;
  } result_t;

  function automatic logic [7:0] cl_name_char(input logic [3:0] idx);
    return (idx < CL_NAME_LEN) ? CL_NAME[idx] : 8'h00;
  endfunction

endpackage

// File: sv/hrbp_parser.sv
// ----------------------------------------------------------------------------
// hrbp_parser: per-byte parse state and result logic
// Holds the parse state, works out the result of the presented byte and moves
// to the next state when the byte is accepted.
// ----------------------------------------------------------------------------
module hrbp_parser import hrbp_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             start_new_i,
  input  logic [CFG_W-1:0] max_body_length_i,
  output result_t          result_o
);

  localparam int LW = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
  localparam int NW = LW + 4;
  localparam logic [LENGTH_BITS-1:0] LMASK = {LENGTH_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_REQ,
    PH_HDR,
    PH_BODY,
    PH_DONE,
    PH_ERR
  } phase_e;

  typedef struct packed {
    logic [1:0]             part;
    logic [NUM_METHODS-1:0] cand;
    logic [3:0]             midx;
    logic [3:0]             mres;
    logic                   line_empty;
    logic                   colon;
    logic [3:0]             nidx;
    logic                   mism;
    logic                   vstart;
    logic [1:0]             vflags;
    logic [LENGTH_BITS-1:0] vnum;
  } line_st_t;

  function automatic line_st_t line_reset(input line_st_t s);
    line_st_t r;
    r            = s;
    r.line_empty = 1'b1;
    r.colon      = 1'b0;
    r.nidx       = '0;
    r.mism       = 1'b0;
    r.vstart     = 1'b0;
    r.vflags     = '0;
    r.vnum       = '0;
    return r;
  endfunction

  function automatic line_st_t request_reset();
    line_st_t r;
    r      = '0;
    r.cand = '1;
    r.mres = METHOD_UNKNOWN;
    return line_reset(r);
  endfunction

  function automatic void req_byte(inout line_st_t s, input logic [7:0] b,
                                   output logic [2:0] cls);
    if (b == CH_SPACE && s.part < 2'd2) begin
      if (s.part == 2'd0) begin
        s.mres = METHOD_UNKNOWN;
        for (int k = NUM_METHODS - 1; k >= 0; k--) begin
          if (s.cand[k] && METHOD_LEN[k] == s.midx) s.mres = 4'(k);
        end
      end
      s.part = s.part + 2'd1;
      cls    = CLS_DELIM;
    end else if (s.part == 2'd0) begin
      for (int k = 0; k < NUM_METHODS; k++) begin
        if (s.midx >= METHOD_LEN[k]) s.cand[k] = 1'b0;
        else if (METHOD_NAME[k][s.midx[2:0]] != b) s.cand[k] = 1'b0;
      end
      if (s.midx != 4'd15) s.midx = s.midx + 4'd1;
      cls = CLS_METHOD;
    end else begin
      cls = 3'(s.part);
    end
  endfunction

  function automatic void hdr_byte(inout line_st_t s, input logic [7:0] b,
                                   input logic [NW-1:0] lim,
                                   output logic [2:0] cls, output logic err);
    logic [NW-1:0] n;
    err = 1'b0;
    n   = '0;
    if (!s.colon) begin
      if (b == CH_COLON) begin
        if (s.line_empty) err = 1'b1;
        s.colon = 1'b1;
        if (s.nidx != CL_NAME_LEN) s.mism = 1'b1;
        cls = CLS_DELIM;
      end else begin
        if (s.mism || s.nidx >= CL_NAME_LEN || cl_name_char(s.nidx) != b) s.mism = 1'b1;
        else s.nidx = s.nidx + 4'd1;
        cls = CLS_NAME;
      end
      s.line_empty = 1'b0;
    end else if (!s.vstart && b == CH_SPACE) begin
      cls = CLS_IGNORED;
    end else begin
      s.vstart = 1'b1;
      if (!s.mism) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          n = (NW'(s.vnum) << 3) + (NW'(s.vnum) << 1) + NW'(b - CH_ZERO);
          s.vflags[0] = 1'b1;
          if (n > lim) s.vflags[1] = 1'b1;
          else s.vnum = n[LENGTH_BITS-1:0];
        end else begin
          s.vflags[1] = 1'b1;
        end
      end
      cls = CLS_VALUE;
    end
  endfunction

  phase_e                 phase_q, phase_d;
  logic                   cr_q, cr_d;
  line_st_t               st_q, st_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;

  logic [NW-1:0] lim;
  logic [2:0]    ev;
  logic [2:0]    cls;
  logic [2:0]    cls_cr;
  logic          err;
  logic          err_cr;
  logic          err_b;

  assign lim = (NW'(max_body_length_i) < NW'(LMASK)) ? NW'(max_body_length_i) : NW'(LMASK);

  always_comb begin
    phase_d  = phase_q;
    cr_d     = cr_q;
    st_d     = st_q;
    len_d    = len_q;
    remain_d = remain_q;
    ev       = EV_NONE;
    cls      = CLS_IGNORED;
    cls_cr   = CLS_IGNORED;
    err      = 1'b0;
    err_cr   = 1'b0;
    err_b    = 1'b0;

    if (start_new_i || phase_q == PH_DONE) begin
      phase_d  = PH_REQ;
      cr_d     = 1'b0;
      st_d     = request_reset();
      len_d    = '0;
      remain_d = '0;
    end

    unique case (phase_d)
      PH_BODY: begin
        cls = CLS_BODY;
        if (remain_d != '0) remain_d = remain_d - LENGTH_BITS'(1);
        if (remain_d == '0) begin
          ev      = EV_COMPLETE;
          phase_d = PH_DONE;
        end else begin
          ev = EV_BODY_BYTE;
        end
      end
      PH_REQ, PH_HDR: begin
        if (cr_d && data_byte_i == CH_LF) begin
          cr_d = 1'b0;
          cls  = CLS_DELIM;
          if (phase_d == PH_REQ) begin
            if (st_d.part != 2'd2) begin
              err = 1'b1;
            end else begin
              ev      = EV_REQ_LINE;
              phase_d = PH_HDR;
              st_d    = line_reset(st_d);
            end
          end else if (st_d.line_empty) begin
            if (len_d == '0) begin
              ev      = EV_COMPLETE;
              phase_d = PH_DONE;
            end else begin
              ev       = EV_HDRS_DONE;
              phase_d  = PH_BODY;
              remain_d = len_d;
            end
          end else if (!st_d.colon) begin
            err = 1'b1;
          end else begin
            if (!st_d.mism) begin
              if (st_d.vflags != 2'b01) err = 1'b1;
              else len_d = st_d.vnum;
            end
            if (!err) begin
              ev   = EV_HDR_LINE;
              st_d = line_reset(st_d);
            end
          end
        end else begin
          if (cr_d) begin
            cr_d = 1'b0;
            if (phase_d == PH_REQ) req_byte(st_d, CH_CR, cls_cr);
            else hdr_byte(st_d, CH_CR, lim, cls_cr, err_cr);
          end
          if (data_byte_i == CH_CR) begin
            cr_d = 1'b1;
            cls  = CLS_DELIM;
          end else if (phase_d == PH_REQ) begin
            req_byte(st_d, data_byte_i, cls);
          end else begin
            hdr_byte(st_d, data_byte_i, lim, cls, err_b);
          end
          err = err_cr | err_b;
        end
      end
      default: begin
        ev = EV_ERROR;
      end
    endcase

    if (err) begin
      ev      = EV_ERROR;
      phase_d = PH_ERR;
      cr_d    = 1'b0;
    end
  end

  always_comb begin
    result_o.event_res   = ev;
    result_o.byte_class  = cls;
    result_o.echo_byte   = data_byte_i;
    result_o.method_code = st_d.mres;
    result_o.body_length = BODY_LEN_W'(len_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_REQ;
      cr_q     <= 1'b0;
      st_q     <= request_reset();
      len_q    <= '0;
      remain_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cr_q     <= cr_d;
      st_q     <= st_d;
      len_q    <= len_d;
      remain_q <= remain_d;
    end
  end

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !start_new_i && phase_q == PH_ERR) |->
      (result_o.event_res == EV_ERROR && result_o.byte_class == CLS_IGNORED))
    else $error("Error phase did not hold its error result.");

  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (remain_q != '0))
    else $error("Body phase entered with no bytes remaining.");

  a_cr_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cr_q |-> (phase_q == PH_REQ || phase_q == PH_HDR))
    else $error("Pending CR outside the request line or header phase.");

endmodule

// File: sv/http_request_byte_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_byte_parser_core: HTTP/1.1 request byte parser
// Tags each byte of a request stream with its role and marks parse events.
// ----------------------------------------------------------------------------
// The input channel carries one byte and a start_new flag per transaction;
// the output channel returns one result per input transaction, in order:
// event, byte class, the byte itself, the method code and the Content-Length
// value in force. Both channels use valid and ready.
// A byte is parsed in the cycle in which it is accepted and its result is
// registered in the output register, or in the skid register during a stall.
// One byte is taken in every cycle while the skid register is empty; the rate
// is set by the combinational parse logic in front of the result register.
// An output register and a skid register hold up to two results, so a byte
// is still accepted in the cycle in which the receiver first stalls; with
// both full, in_ready_o falls until the receiver takes a result. cfg_we_i
// writes cfg_wdata_i to the limit register, which the user must write only
// while the block is idle, which it does not enforce. Reset clears the parse
// state to a new request line, empties both result registers, sets limit 1048576.
// ----------------------------------------------------------------------------
module http_request_byte_parser_core import hrbp_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_new_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            event_res_o,
  output logic [2:0]            byte_class_o,
  output logic [7:0]            echo_byte_o,
  output logic [3:0]            method_code_o,
  output logic [BODY_LEN_W-1:0] body_length_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  logic [CFG_W-1:0] max_body_q;
  result_t          res;
  result_t          main_q;
  result_t          skid_q;
  logic             main_v_q;
  logic             skid_v_q;
  logic             accept;
  logic             taken;

  assign in_ready_o = !skid_v_q;
  assign accept     = in_valid_i && in_ready_o;
  assign taken      = main_v_q && out_ready_i;

  hrbp_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .data_byte_i       (data_byte_i),
    .start_new_i       (start_new_i),
    .max_body_length_i (max_body_q),
    .result_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MAX_BODY_RESET;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
      main_q   <= '0;
      skid_q   <= '0;
    end else begin
      if (taken) begin
        if (skid_v_q) begin
          main_q   <= skid_q;
          skid_v_q <= 1'b0;
        end else if (accept) begin
          main_q <= res;
        end else begin
          main_v_q <= 1'b0;
        end
      end else if (!main_v_q) begin
        if (accept) begin
          main_q   <= res;
          main_v_q <= 1'b1;
        end
      end else if (accept) begin
        skid_q   <= res;
        skid_v_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = main_v_q;
  assign event_res_o   = main_q.event_res;
  assign byte_class_o  = main_q.byte_class;
  assign echo_byte_o   = main_q.echo_byte;
  assign method_code_o = main_q.method_code;
  assign body_length_o = main_q.body_length;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("Skid register holds a result while the output register is empty.");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_v_q && !out_ready_i && accept) |=> skid_v_q)
    else $error("Transaction accepted during a stall was not kept in the skid register.");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_ready_i) |=> (main_v_q && !skid_v_q))
    else $error("Skid register did not drain into the output register.");

endmodule

// File: tb/http_request_byte_parser_checker.sv
// ----------------------------------------------------------------------------
// http_request_byte_parser_checker: result checker of the HTTP byte parser
// Watches the input, output and limit ports of the parser, predicts the result
// of every input transaction from its own copy of the parse state and compares
// each output transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_byte_parser_checker import hrbp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_new_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [2:0]            event_res_i,
  input  logic [2:0]            byte_class_i,
  input  logic [7:0]            echo_byte_i,
  input  logic [3:0]            method_code_i,
  input  logic [BODY_LEN_W-1:0] body_length_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef enum logic [2:0] {
    PH_REQUEST, PH_HEADER, PH_BODY, PH_DONE, PH_ERROR
  } parse_phase_e;

  parse_phase_e           phase;
  logic [1:0]             req_part;
  logic                   cr_pending;
  logic [NUM_METHODS-1:0] method_cands;
  logic [3:0]             method_idx;
  logic [3:0]             method_res;
  logic                   line_empty;
  logic                   colon_seen;
  logic [3:0]             name_idx;
  logic                   name_mismatch;
  logic                   value_started;
  logic [1:0]             value_flags;
  logic [BODY_LEN_W-1:0]  value_num;
  logic [BODY_LEN_W-1:0]  length_now;
  logic [BODY_LEN_W-1:0]  body_left;
  logic [CFG_W-1:0]       max_body;

  result_t expected_results[$];
  result_t want;
  result_t got;
  int      fails = 0;

  function automatic void clear_line();
    line_empty    = 1'b1;
    colon_seen    = 1'b0;
    name_idx      = '0;
    name_mismatch = 1'b0;
    value_started = 1'b0;
    value_num     = '0;
    value_flags   = '0;
  endfunction

  function automatic void begin_request();
    phase        = PH_REQUEST;
    req_part     = '0;
    cr_pending   = 1'b0;
    method_cands = '1;
    method_idx   = '0;
    method_res   = METHOD_UNKNOWN;
    clear_line();
    length_now   = '0;
    body_left    = '0;
  endfunction

  function automatic logic [2:0] request_line_byte(input logic [7:0] b);
    if (b == CH_SPACE && req_part < 2'd2) begin
      if (req_part == 2'd0) begin
        method_res = METHOD_UNKNOWN;
        for (int k = NUM_METHODS - 1; k >= 0; k--) begin
          if (method_cands[k] && METHOD_LEN[k] == method_idx) method_res = 4'(k);
        end
      end
      req_part++;
      return CLS_DELIM;
    end
    if (req_part == 2'd0) begin
      for (int k = 0; k < NUM_METHODS; k++) begin
        if (method_idx >= METHOD_LEN[k]) method_cands[k] = 1'b0;
        else if (METHOD_NAME[k][method_idx[2:0]] != b) method_cands[k] = 1'b0;
      end
      if (method_idx < 4'd15) method_idx++;
      return CLS_METHOD;
    end
    return (req_part == 2'd1) ? CLS_PATH : CLS_VERSION;
  endfunction

  function automatic logic [2:0] header_byte(input logic [7:0] b, inout logic err);
    logic [31:0] acc;
    if (!colon_seen) begin
      if (b == CH_COLON) begin
        if (line_empty) err = 1'b1;
        colon_seen = 1'b1;
        if (name_idx != CL_NAME_LEN) name_mismatch = 1'b1;
        line_empty = 1'b0;
        return CLS_DELIM;
      end
      if (name_mismatch || name_idx >= CL_NAME_LEN) name_mismatch = 1'b1;
      else if (CL_NAME[name_idx] != b) name_mismatch = 1'b1;
      else name_idx++;
      line_empty = 1'b0;
      return CLS_NAME;
    end
    if (!value_started && b == CH_SPACE) return CLS_IGNORED;
    value_started = 1'b1;
    if (!name_mismatch) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        acc = 32'(value_num) * 32'd10 + 32'(b - CH_ZERO);
        value_flags[0] = 1'b1;
        if (acc > 32'(max_body)) value_flags[1] = 1'b1;
        else value_num = acc[BODY_LEN_W-1:0];
      end else begin
        value_flags[1] = 1'b1;
      end
    end
    return CLS_VALUE;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b, input logic restart);
    result_t    r;
    logic       err;
    logic [2:0] ev;
    logic [2:0] cls;
    err = 1'b0;
    ev  = EV_NONE;
    cls = CLS_IGNORED;
    if (restart || phase == PH_DONE) begin_request();
    if (phase == PH_ERROR) begin
      ev = EV_ERROR;
    end else if (phase == PH_BODY) begin
      cls = CLS_BODY;
      if (body_left > 0) body_left--;
      if (body_left == 0) begin
        ev    = EV_COMPLETE;
        phase = PH_DONE;
      end else begin
        ev = EV_BODY_BYTE;
      end
    end else if (cr_pending && b == CH_LF) begin
      cr_pending = 1'b0;
      cls        = CLS_DELIM;
      if (phase == PH_REQUEST) begin
        if (req_part != 2'd2) begin
          err = 1'b1;
        end else begin
          ev    = EV_REQ_LINE;
          phase = PH_HEADER;
          clear_line();
        end
      end else if (line_empty) begin
        if (length_now == 0) begin
          ev    = EV_COMPLETE;
          phase = PH_DONE;
        end else begin
          ev        = EV_HDRS_DONE;
          phase     = PH_BODY;
          body_left = length_now;
        end
      end else if (!colon_seen) begin
        err = 1'b1;
      end else begin
        if (!name_mismatch) begin
          if (value_flags != 2'b01) err = 1'b1;
          else length_now = value_num;
        end
        if (!err) begin
          ev = EV_HDR_LINE;
          clear_line();
        end
      end
    end else begin
      // A carriage return that was not followed by a line feed is line content.
      if (cr_pending) begin
        cr_pending = 1'b0;
        if (phase == PH_REQUEST) void'(request_line_byte(CH_CR));
        else void'(header_byte(CH_CR, err));
      end
      if (b == CH_CR) begin
        cr_pending = 1'b1;
        cls        = CLS_DELIM;
      end else if (phase == PH_REQUEST) begin
        cls = request_line_byte(b);
      end else begin
        cls = header_byte(b, err);
      end
    end
    if (err) begin
      ev         = EV_ERROR;
      phase      = PH_ERROR;
      cr_pending = 1'b0;
    end
    r.event_res   = ev;
    r.byte_class  = cls;
    r.echo_byte   = b;
    r.method_code = method_res;
    r.body_length = length_now;
    return r;
  endfunction

  function automatic void compare_field(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body = MAX_BODY_RESET;
      begin_request();
      expected_results.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.event_res   = event_res_i;
        got.byte_class  = byte_class_i;
        got.echo_byte   = echo_byte_i;
        got.method_code = method_code_i;
        got.body_length = body_length_i;
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result transaction with none outstanding, event %0d byte %0d",
                   $time, got.event_res, got.echo_byte);
        end else begin
          want = expected_results.pop_front();
          compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
          compare_field("byte_class", 32'(want.byte_class), 32'(got.byte_class));
          compare_field("echo_byte", 32'(want.echo_byte), 32'(got.echo_byte));
          compare_field("method_code", 32'(want.method_code), 32'(got.method_code));
          compare_field("body_length", 32'(want.body_length), 32'(got.body_length));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(parse_byte(data_byte_i, start_new_i));
      end
      if (cfg_we_i) max_body = cfg_wdata_i;
      pending_o    <= expected_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the HTTP request byte parser
// Drives short directed byte streams and then mostly well-formed requests with
// random content, Content-Length values around the limit, broken lines and
// noise, under several limit settings and random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hrbp_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_CYCLES     = 200;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int NUM_PHASES      = 6;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i = '0;
  logic                  start_new_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            event_res_o;
  logic [2:0]            byte_class_o;
  logic [7:0]            echo_byte_o;
  logic [3:0]            method_code_o;
  logic [BODY_LEN_W-1:0] body_length_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int items_sent  = 0;
  int max_len     = int'(MAX_BODY_RESET);
  bit restart_next = 1'b0;
  bit clean_end    = 1'b1;
  bit gaps_on      = 1'b1;
  bit hold_req     = 1'b0;

  http_request_byte_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .start_new_i   (start_new_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .byte_class_o  (byte_class_o),
    .echo_byte_o   (echo_byte_o),
    .method_code_o (method_code_o),
    .body_length_o (body_length_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  http_request_byte_parser_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .start_new_i   (start_new_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_i   (event_res_o),
    .byte_class_i  (byte_class_o),
    .echo_byte_i   (echo_byte_o),
    .method_code_i (method_code_o),
    .body_length_i (body_length_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** http_request_byte_parser_core: FAILED **");
    $finish;
  end

  initial begin : receiver
    int stall_left;
    int mode_left;
    int rx_mode;
    int hold_cnt;
    stall_left = 0;
    mode_left  = 0;
    rx_mode    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rx_mode == 0) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        stall_left = $urandom_range(10, 40);
        out_ready_i <= 1'b0;
      end else if (rx_mode == 1) begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    int roll;
    bit spont;
    gap = 0;
    if (gaps_on) begin
      roll = $urandom_range(0, 39);
      if (roll < 6) gap = 1;
      else if (roll < 9) gap = $urandom_range(2, 4);
      else if (roll == 9) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    spont = ($urandom_range(0, 199) == 0);
    if (spont) clean_end = 1'b0;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    start_new_i <= restart_next || spont;
    restart_next = 1'b0;
    items_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = int'(v);
  endtask

  task automatic send_request();
    int pick;
    int n;
    int k;
    int ln;
    int lines;
    int m;
    int cl_val;
    int body_len;
    bit doomed;
    doomed   = 1'b0;
    body_len = 0;
    restart_next = !clean_end || ($urandom_range(0, 1) == 1);
    clean_end = 1'b1;

    pick = $urandom_range(0, 11);
    if (pick < NUM_METHODS) begin
      for (k = 0; k < METHOD_LEN[pick]; k++) send_byte(METHOD_NAME[pick][k]);
    end else if (pick == NUM_METHODS) begin
      n = $urandom_range(0, 8);
      for (k = 0; k < n; k++) send_byte(8'($urandom_range(65, 90)));
    end else begin
      // A known method cut short by one letter or followed by one more.
      m = $urandom_range(0, NUM_METHODS - 1);
      n = (pick == 10) ? METHOD_LEN[m] - 1 : METHOD_LEN[m] + 1;
      for (k = 0; k < n; k++) begin
        if (k < METHOD_LEN[m]) send_byte(METHOD_NAME[m][k]);
        else send_byte(8'($urandom_range(65, 90)));
      end
    end
    send_byte(CH_SPACE);
    n = $urandom_range(0, 6);
    for (k = 0; k < n; k++) send_byte(8'($urandom_range(33, 126)));
    if ($urandom_range(0, 19) == 0) doomed = 1'b1;
    else send_byte(CH_SPACE);
    if ($urandom_range(0, 4) != 0) begin
      send_text("HTTP/1.1");
    end else begin
      n = $urandom_range(0, 9);
      for (k = 0; k < n; k++) send_byte(8'($urandom_range(32, 126)));
    end
    send_crlf();

    lines = $urandom_range(0, 3);
    for (ln = 0; ln < lines; ln++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        send_text("Content-Length");
        send_byte(CH_COLON);
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) send_byte(CH_SPACE);
        pick = $urandom_range(0, 19);
        if (pick < 13) cl_val = $urandom_range(0, 12);
        else if (pick < 15) cl_val = max_len;
        else if (pick == 15) cl_val = max_len + 1;
        else if (pick == 16) cl_val = 2097152 + $urandom_range(0, 9999999);
        else cl_val = -1;
        if (cl_val >= 0) begin
          if ($urandom_range(0, 3) == 0) send_byte(CH_ZERO);
          send_text($sformatf("%0d", cl_val));
          if (cl_val > max_len) doomed = 1'b1;
          else body_len = cl_val;
        end else begin
          case ($urandom_range(0, 2))
            0: ;
            1: send_text("1x");
            default: send_text("4 2");
          endcase
          doomed = 1'b1;
        end
      end else if (pick < 12) begin
        case ($urandom_range(0, 3))
          0: send_text("content-length");
          1: send_text("Content-Lengt");
          2: send_text("Content-Lengths");
          default: send_text("Content-Length ");
        endcase
        send_byte(CH_COLON);
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) send_byte(8'($urandom_range(32, 126)));
      end else if (pick < 19) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 5) == 0) send_byte("-");
          else send_byte(8'($urandom_range(97, 122)));
        end
        send_byte(CH_COLON);
        n = $urandom_range(0, 10);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 15))
            0: send_byte(CH_CR);
            1: send_byte(CH_LF);
            default: send_byte(8'($urandom_range(32, 126)));
          endcase
        end
        if ($urandom_range(0, 7) == 0) send_byte(CH_CR);
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          send_text("NoColon");
        end else begin
          send_byte(CH_COLON);
          send_text("v");
        end
        doomed = 1'b1;
      end
      send_crlf();
    end
    send_crlf();

    if (!doomed && body_len > 0) begin
      if (body_len > 24) begin
        n = $urandom_range(1, 8);
        clean_end = 1'b0;
      end else begin
        n = body_len;
      end
      for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
    end
    if (doomed) clean_end = 1'b0;
  endtask

  task automatic send_noise();
    int n;
    restart_next = 1'($urandom_range(0, 1));
    n = $urandom_range(1, 16);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 7))
        0: send_byte(CH_CR);
        1: send_byte(CH_LF);
        2: send_byte(CH_SPACE);
        3: send_byte(CH_COLON);
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    clean_end = 1'b0;
  endtask

  initial begin : stimulus
    int ph;
    int phase_start;
    logic [CFG_W-1:0] lim;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty path and version are allowed.
    restart_next = 1'b1;
    send_text("GET  ");
    send_crlf();
    // A colon opening a header line is an error, and the error is sticky.
    send_byte(CH_COLON);
    send_byte(8'hFF);
    // A lone carriage return and a bare line feed are content of the method.
    restart_next = 1'b1;
    send_byte(8'h00);
    send_byte(CH_CR);
    send_text("x");
    send_byte(CH_LF);
    send_crlf();
    // An empty method, no headers and no body complete the request at once.
    restart_next = 1'b1;
    send_text("  ");
    send_crlf();
    send_crlf();
    send_text("H");
    clean_end = 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: lim = MAX_BODY_RESET;
        1: lim = '0;
        2: lim = 21'd1048575;
        3: lim = 21'd5;
        4: lim = CFG_W'($urandom_range(0, 1048576));
        default: lim = MAX_BODY_RESET;
      endcase
      write_limit(lim);
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        if (ph == 2 && items_sent == phase_start) begin
          // Keep offering bytes while the receiver holds off, so the block fills up.
          hold_req = 1'b1;
          gaps_on  = 1'b0;
        end
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_request();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** http_request_byte_parser_core: PASSED **");
    end else begin
      $display("** http_request_byte_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
